// File: rtl/core/distinct_value_dictionary_unit_assert.svh
// Assertion macros used by the checker file of the dictionary unit.
`ifndef DISTINCT_VALUE_DICTIONARY_UNIT_ASSERT_SVH
`define DISTINCT_VALUE_DICTIONARY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DVD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dictionary unit check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DVD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dictionary unit check failed");

`endif

// File: rtl/core/dvd_pkg.sv
// Shared constants, types and helper function of the dictionary unit.
package dvd_pkg;

    localparam int DISTINCT_LIMIT_DEF = 256;
    localparam int TABLE_DEPTH_DEF    = 512;
    localparam int VALUE_W            = 64;
    localparam int INDEX_W            = 9;

    localparam logic [VALUE_W-1:0] NEG_ZERO_BITS = 64'h8000_0000_0000_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // Word accepted: latch key and flags.
        logic rd;       // Read the table entry at the search pointer.
        logic advance;  // Compared entry did not match: step the pointer.
        logic hit;      // Compared entry matched: build the result.
        logic miss;     // Search exhausted: insert or flag a full table.
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic limit_hit;  // Sticky stop flag.
        logic more;       // Search pointer is below the entry count.
        logic match;      // Registered read data equals the key.
    } t_dp_stat;

    // Minus zero is stored and compared as plus zero.
    function automatic logic [VALUE_W-1:0] canonical(input logic [VALUE_W-1:0] bits);
        canonical = (bits == NEG_ZERO_BITS) ? '0 : bits;
    endfunction

endpackage

// File: rtl/core/distinct_value_dictionary_unit.sv
// A word whose value matches an entry gives its result once the search reaches that entry;
// a new value gives it after every entry of the stripe has been compared.
// A word that arrives after the stop flag is set gives its result the cycle after acceptance.
// One word at a time; the single read port takes a read state and a compare state per entry.
// Reset clears the entry count, the stop flag and the controller; table contents are not cleared.
module distinct_value_dictionary_unit #(
    parameter int DISTINCT_LIMIT = dvd_pkg::DISTINCT_LIMIT_DEF,
    parameter int TABLE_DEPTH    = dvd_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [dvd_pkg::VALUE_W-1:0] i_value_bits,
    input  logic                        i_new_stripe,
    input  logic                        i_row_last,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [dvd_pkg::INDEX_W-1:0] o_value_index,
    output logic                        o_is_new,
    output logic                        o_table_full,
    output logic                        o_stopped,
    output logic                        o_few_distinct
);

    dvd_pkg::t_dp_cmd  w_cmd;
    dvd_pkg::t_dp_stat w_stat;

    dvd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    dvd_datapath #(
        .DISTINCT_LIMIT (DISTINCT_LIMIT),
        .TABLE_DEPTH    (TABLE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value_bits   (i_value_bits),
        .i_new_stripe   (i_new_stripe),
        .i_row_last     (i_row_last),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_value_index  (o_value_index),
        .o_is_new       (o_is_new),
        .o_table_full   (o_table_full),
        .o_stopped      (o_stopped),
        .o_few_distinct (o_few_distinct)
    );

endmodule

// File: rtl/core/dvd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module dvd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/dvd_ctrl.sv
// Controller state machine: sequences the linear search of the dictionary.
module dvd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  dvd_pkg::t_dp_stat i_stat,
    output dvd_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_CMP  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // A stopped word needs no search.
                    n_state = i_stat.limit_hit ? S_OUT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.more) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CMP;
                end else begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_OUT;
                end
            end
            S_CMP: begin
                if (i_stat.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_OUT;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

// File: rtl/core/dvd_datapath.sv
// Datapath: key register, entry count, search pointer, value table and result registers.
module dvd_datapath #(
    parameter int DISTINCT_LIMIT = dvd_pkg::DISTINCT_LIMIT_DEF,
    parameter int TABLE_DEPTH    = dvd_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [dvd_pkg::VALUE_W-1:0]  i_value_bits,
    input  logic                         i_new_stripe,
    input  logic                         i_row_last,
    input  dvd_pkg::t_dp_cmd             i_cmd,
    output dvd_pkg::t_dp_stat            o_stat,
    output logic [dvd_pkg::INDEX_W-1:0]  o_value_index,
    output logic                         o_is_new,
    output logic                         o_table_full,
    output logic                         o_stopped,
    output logic                         o_few_distinct
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [31:0]   LIMIT_C = 32'(DISTINCT_LIMIT);

    logic [dvd_pkg::VALUE_W-1:0] r_key;
    logic                        r_last;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic [CW-1:0]               r_ptr;
    logic                        r_limit_hit;
    logic                        n_limit_hit;
    logic [dvd_pkg::VALUE_W-1:0] w_rdata;
    logic                        w_space;
    logic                        w_we;
    logic [CW-1:0]               w_res_pos;
    logic [31:0]                 w_pos_ext;
    logic [31:0]                 w_count_ext;

    logic [dvd_pkg::INDEX_W-1:0] r_index;
    logic                        r_is_new;
    logic                        r_full;
    logic                        r_stopped;
    logic                        r_few;

    dvd_ram #(
        .WIDTH (dvd_pkg::VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_key),
        .i_re    (i_cmd.rd),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_space = (r_count < DEPTH_C);
    assign w_we    = i_cmd.miss && w_space;

    // Entry count after this word, used by the row-end limit check.
    always_comb begin
        n_count = r_count;
        if (w_we) begin
            n_count = r_count + CW'(1);
        end
    end

    assign w_count_ext = 32'(n_count);
    assign n_limit_hit = r_limit_hit || (r_last && (w_count_ext >= LIMIT_C));

    assign w_res_pos = i_cmd.hit ? r_ptr : r_count;
    assign w_pos_ext = 32'(w_res_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_limit_hit <= 1'b0;
        end else begin
            if (i_cmd.load && !r_limit_hit && i_new_stripe) begin
                r_count <= '0;
            end else if (i_cmd.miss) begin
                r_count <= n_count;
            end
            if (i_cmd.hit || i_cmd.miss) begin
                r_limit_hit <= n_limit_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= dvd_pkg::canonical(i_value_bits);
            r_last <= i_row_last;
            r_ptr  <= '0;
        end else if (i_cmd.advance) begin
            r_ptr <= r_ptr + CW'(1);
        end

        if (i_cmd.load) begin
            // Only a stopped word leaves its result here; others are overwritten later.
            r_index   <= '0;
            r_is_new  <= 1'b0;
            r_full    <= 1'b0;
            r_stopped <= r_limit_hit;
            r_few     <= !r_limit_hit;
        end else if (i_cmd.hit || i_cmd.miss) begin
            r_index   <= (i_cmd.hit || w_space) ? w_pos_ext[dvd_pkg::INDEX_W-1:0] : '0;
            r_is_new  <= w_we;
            r_full    <= i_cmd.miss && !w_space;
            r_stopped <= 1'b0;
            r_few     <= !n_limit_hit;
        end
    end

    assign o_stat.limit_hit = r_limit_hit;
    assign o_stat.more      = (r_ptr < r_count);
    assign o_stat.match     = (w_rdata == r_key);

    assign o_value_index  = r_index;
    assign o_is_new       = r_is_new;
    assign o_table_full   = r_full;
    assign o_stopped      = r_stopped;
    assign o_few_distinct = r_few;

endmodule

// File: rtl/core/dvd_checker.sv
// Port-level checker of the dictionary unit and its bind to the top level.
`include "distinct_value_dictionary_unit_assert.svh"

module dvd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [dvd_pkg::INDEX_W-1:0] o_value_index,
    input logic                        o_is_new,
    input logic                        o_table_full,
    input logic                        o_stopped,
    input logic                        o_few_distinct
);

    // A result word stays offered until it is taken.
    `DVD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // A stopped word carries no other information.
    `DVD_ASSERT_NOW(a_stop_clean, i_clk, i_rst_n, o_out_valid && o_stopped, (o_value_index == '0) && !o_is_new && !o_table_full && !o_few_distinct)

    // An insertion and a full table exclude each other.
    `DVD_ASSERT_NOW(a_new_xor_full, i_clk, i_rst_n, o_out_valid, !(o_is_new && o_table_full))

    // A value that found no free entry reports index zero.
    `DVD_ASSERT_NOW(a_full_index, i_clk, i_rst_n, o_out_valid && o_table_full, o_value_index == '0)

endmodule

bind distinct_value_dictionary_unit dvd_checker u_dvd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_value_index  (o_value_index),
    .o_is_new       (o_is_new),
    .o_table_full   (o_table_full),
    .o_stopped      (o_stopped),
    .o_few_distinct (o_few_distinct)
);
